// ===== hdl/fall_impact_detector_core_assert.svh =====
// Assertion macros shared by the fall and impact detector RTL.
// Depends on nothing; included by the modules that carry checks.
`ifndef FALL_IMPACT_DETECTOR_CORE_ASSERT_SVH
`define FALL_IMPACT_DETECTOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define FID_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fall_impact_detector_core: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define FID_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fall_impact_detector_core: next-cycle check failed");

`endif

// ===== hdl/fid_pkg.sv =====
// Package for the fall and impact detector: payload types, front FSM states,
// register indexes, reset values and fixed constants. Depends on nothing.
`default_nettype none

package fid_pkg;

  // One accelerometer sample
  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic [31:0]        now_ms;
  } sample_t;

  // One result
  typedef struct packed {
    logic [15:0] magnitude;
    logic        freefall_event;
    logic [15:0] freefall_peak;
    logic        impact_event;
  } result_t;

  // Item passed from the magnitude front end to the event back end
  typedef struct packed {
    logic [15:0] magnitude;
    logic [31:0] now_ms;
  } mid_item_t;

  // Magnitude front end states
  typedef enum logic [1:0] {
    FR_IDLE,
    FR_SQUARE,
    FR_ROOT,
    FR_DONE
  } front_state_t;

  // Register indexes
  localparam logic [2:0] CFG_FREEFALL_THRESHOLD = 3'd0;
  localparam logic [2:0] CFG_FREEFALL_MIN       = 3'd1;
  localparam logic [2:0] CFG_IMPACT_THRESHOLD   = 3'd2;
  localparam logic [2:0] CFG_COOLDOWN_SECONDS   = 3'd3;
  localparam logic [2:0] CFG_SAMPLE_PERIOD      = 3'd4;

  // Register reset values
  localparam logic [15:0] RST_FREEFALL_THRESHOLD = 16'd400;
  localparam logic [15:0] RST_FREEFALL_MIN       = 16'd100;
  localparam logic [15:0] RST_IMPACT_THRESHOLD   = 16'd3000;
  localparam logic [11:0] RST_COOLDOWN_SECONDS   = 12'd5;
  localparam logic [7:0]  RST_SAMPLE_PERIOD      = 8'd16;
  localparam logic [21:0] RST_COOLDOWN_MS        = 22'd5000;

  // Fixed levels
  localparam logic [15:0] REARM_LEVEL_MG = 16'd800;
  localparam logic [15:0] PEAK_FLOOR_MG  = 16'd1000;
  localparam logic [9:0]  MS_PER_SECOND  = 10'd1000;
  localparam logic [15:0] LOW_TIME_MAX   = 16'hFFFF;

  // Square root iterations and starting bit for a 32-bit radicand
  localparam logic [3:0]  ROOT_LAST_ITER = 4'd15;
  localparam logic [31:0] ROOT_TOP_BIT   = 32'h4000_0000;

endpackage

`default_nettype wire

// ===== hdl/fid_front.sv =====
// Magnitude front end: squares the three axes on one shared multiplier and
// takes the integer square root one result bit per cycle. Uses fid_pkg.
`default_nettype none

module fid_front import fid_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire sample_t   sample,
  output logic           full,
  input  wire logic      mid_full,
  output logic           mid_push,
  output mid_item_t      mid_item
);

  front_state_t state, state_next;

  logic signed [15:0] ax, ay, az;
  logic [31:0] now_q;
  logic [1:0]  step;
  logic [31:0] prod;
  logic [31:0] acc;
  logic [31:0] rem;
  logic [31:0] root;
  logic [31:0] sq_bit;
  logic [3:0]  iter;

  logic signed [15:0] axis;
  logic signed [31:0] sq;
  logic [31:0]        trial;

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequence capture, squaring, root and hand-off
  always_comb begin
    state_next = state;
    full       = 1'b1;
    mid_push   = 1'b0;
    case (state)
      FR_IDLE: begin
        full = 1'b0;
        if (push) begin
          state_next = FR_SQUARE;
        end
      end
      FR_SQUARE: begin
        if (step == 2'd3) begin
          state_next = FR_ROOT;
        end
      end
      FR_ROOT: begin
        if (iter == 4'd0) begin
          state_next = FR_DONE;
        end
      end
      FR_DONE: begin
        if (!mid_full) begin
          mid_push   = 1'b1;
          state_next = FR_IDLE;
        end
      end
      default: begin
        state_next = FR_IDLE;
      end
    endcase
  end

  // Select the axis for the shared multiplier
  always_comb begin
    case (step)
      2'd0:    axis = ax;
      2'd1:    axis = ay;
      default: axis = az;
    endcase
  end

  assign sq    = axis * axis;
  assign trial = root + sq_bit;

  // Advance the datapath
  always_ff @(posedge clk) begin
    case (state)
      FR_IDLE: begin
        if (push) begin
          ax    <= sample.accel_x;
          ay    <= sample.accel_y;
          az    <= sample.accel_z;
          now_q <= sample.now_ms;
          step  <= 2'd0;
          acc   <= 32'd0;
        end
      end
      FR_SQUARE: begin
        if (step != 2'd3) begin
          prod <= 32'(sq);
        end
        if (step != 2'd0) begin
          acc <= acc + prod;
        end
        if (step == 2'd3) begin
          rem    <= acc + prod;
          root   <= 32'd0;
          sq_bit <= ROOT_TOP_BIT;
          iter   <= ROOT_LAST_ITER;
        end
        step <= step + 2'd1;
      end
      FR_ROOT: begin
        if (rem >= trial) begin
          rem  <= rem - trial;
          root <= (root >> 1) + sq_bit;
        end else begin
          root <= root >> 1;
        end
        sq_bit <= sq_bit >> 2;
        iter   <= iter - 4'd1;
      end
      default: begin
      end
    endcase
  end

  assign mid_item.magnitude = root[15:0];
  assign mid_item.now_ms    = now_q;

endmodule

`default_nettype wire

// ===== hdl/fid_queue.sv =====
// Two-entry register queue between the magnitude front end and the event
// back end. Uses fid_pkg for the item type.
`default_nettype none

module fid_queue import fid_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire mid_item_t din,
  output logic           full,
  input  wire logic      pop,
  output mid_item_t      dout,
  output logic           empty
);

  mid_item_t   entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_push;
  logic        do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entries[rd_ptr];

  // Store on push
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= din;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/fid_back.sv =====
// Event back end: configuration registers, free-fall and impact decisions,
// cooldown and the result register. Uses fid_pkg and the assertion macros.
`default_nettype none
`include "fall_impact_detector_core_assert.svh"

module fid_back import fid_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wen,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  input  wire mid_item_t   item,
  input  wire logic        item_valid,
  output logic             item_take,
  output result_t          result,
  output logic             empty,
  input  wire logic        pop
);

  logic [15:0] freefall_threshold_mg;
  logic [15:0] freefall_min_ms;
  logic [15:0] impact_threshold_mg;
  logic [11:0] cooldown_seconds;
  logic [7:0]  sample_step_ms;
  logic [21:0] cooldown_ms;

  logic [15:0] low_time_ms, low_time_ms_next;
  logic        reported, reported_next;
  logic [15:0] peak_magnitude, peak_magnitude_next;
  logic [31:0] last_event_time, last_event_time_next;
  logic        event_seen, event_seen_next;
  logic        out_valid;

  logic        fire;
  logic [31:0] since;
  logic        cooldown;
  logic [15:0] peak_max;
  logic [16:0] lt_sum;
  logic [15:0] lt_sat;
  logic        is_low;
  logic        ff_hit;
  logic        imp_hit;
  logic [15:0] ff_peak;
  logic        take_event;

  // Write configuration registers; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      freefall_threshold_mg <= RST_FREEFALL_THRESHOLD;
      freefall_min_ms       <= RST_FREEFALL_MIN;
      impact_threshold_mg   <= RST_IMPACT_THRESHOLD;
      cooldown_seconds      <= RST_COOLDOWN_SECONDS;
      sample_step_ms        <= RST_SAMPLE_PERIOD;
      cooldown_ms           <= RST_COOLDOWN_MS;
    end else begin
      cooldown_ms <= 22'(cooldown_seconds) * 22'(MS_PER_SECOND);
      if (cfg_wen) begin
        case (cfg_index)
          CFG_FREEFALL_THRESHOLD: freefall_threshold_mg <= cfg_wdata;
          CFG_FREEFALL_MIN:       freefall_min_ms       <= cfg_wdata;
          CFG_IMPACT_THRESHOLD:   impact_threshold_mg   <= cfg_wdata;
          CFG_COOLDOWN_SECONDS:   cooldown_seconds      <= cfg_wdata[11:0];
          CFG_SAMPLE_PERIOD:      sample_step_ms        <= cfg_wdata[7:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Take an item when the result register is free or being drained
  assign fire      = item_valid && (!out_valid || pop);
  assign item_take = fire;
  assign empty     = !out_valid;

  // Decide cooldown, free fall and impact for the item at the queue head
  always_comb begin
    since    = item.now_ms - last_event_time;
    cooldown = event_seen && (since < {10'd0, cooldown_ms});
    peak_max = (item.magnitude > peak_magnitude) ? item.magnitude : peak_magnitude;
    lt_sum   = {1'b0, low_time_ms} + {9'd0, sample_step_ms};
    lt_sat   = lt_sum[16] ? LOW_TIME_MAX : lt_sum[15:0];
    is_low   = item.magnitude < freefall_threshold_mg;
    ff_hit   = is_low && (lt_sat >= freefall_min_ms) && !reported && !cooldown;
    imp_hit  = (item.magnitude > impact_threshold_mg) && !cooldown;
    ff_peak  = 16'd0;
    if (ff_hit) begin
      ff_peak = (peak_max > PEAK_FLOOR_MG) ? peak_max : PEAK_FLOOR_MG;
    end

    low_time_ms_next     = low_time_ms;
    reported_next        = reported;
    peak_magnitude_next  = peak_max;
    last_event_time_next = last_event_time;
    event_seen_next      = event_seen;
    if (is_low) begin
      low_time_ms_next = lt_sat;
    end else if (item.magnitude > REARM_LEVEL_MG) begin
      low_time_ms_next = 16'd0;
      reported_next    = 1'b0;
    end
    if (ff_hit) begin
      reported_next = 1'b1;
    end
    if (ff_hit || imp_hit) begin
      peak_magnitude_next  = 16'd0;
      last_event_time_next = item.now_ms;
      event_seen_next      = 1'b1;
    end
  end

  // Update detector state
  always_ff @(posedge clk) begin
    if (rst) begin
      low_time_ms     <= 16'd0;
      reported        <= 1'b0;
      peak_magnitude  <= 16'd0;
      last_event_time <= 32'd0;
      event_seen      <= 1'b0;
    end else if (fire) begin
      low_time_ms     <= low_time_ms_next;
      reported        <= reported_next;
      peak_magnitude  <= peak_magnitude_next;
      last_event_time <= last_event_time_next;
      event_seen      <= event_seen_next;
    end
  end

  // Hold the result until popped
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result.magnitude      <= item.magnitude;
      result.freefall_event <= ff_hit;
      result.freefall_peak  <= ff_peak;
      result.impact_event   <= imp_hit;
    end
  end

  // Flag a taken item that reports any event
  assign take_event = fire && (ff_hit || imp_hit);

  `FID_ASSERT_NXT(a_ff_sets_reported, clk, rst, fire && ff_hit, reported)
  `FID_ASSERT_NXT(a_event_marks_seen, clk, rst, take_event, event_seen)
  `FID_ASSERT_NXT(a_event_stamps_time, clk, rst, take_event, last_event_time == $past(item.now_ms))
  `FID_ASSERT_NXT(a_event_clears_peak, clk, rst, take_event, peak_magnitude == 16'd0)

endmodule

`default_nettype wire

// ===== hdl/fall_impact_detector_core.sv =====
// Fall and impact detector, top level: magnitude front end, two-entry queue
// and event back end. Uses fid_pkg, fid_front, fid_queue and fid_back.
//
// Usage:
//   Input side is a queue: drive sample and push; the sample is taken at a
//   clock edge with push high and full low. Result side is a queue: while
//   empty is low, result holds the oldest result; pop at an edge with empty
//   low takes it. Every sample gives exactly one result, in order.
//   Configuration: cfg_wen, cfg_index, cfg_wdata write one register per
//   edge; only while no sample is in flight. Unknown indexes are ignored.
//   Path from accept to result: the three squares on one shared 16x16
//   multiplier, sixteen square root iterations at one result bit per
//   cycle, a hand-off into the queue and an event decision into the result
//   register. The front end works on one sample at a time: full stays high
//   from accept until its magnitude is handed to the queue.
//   Stall: a held result does not stop the front end; up to two magnitudes
//   wait in the queue, after which full stays high until pop.
//   Reset (rst, synchronous): registers return to their defaults, detector
//   state clears, the queue and result register empty.
`default_nettype none

module fall_impact_detector_core import fid_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire sample_t     sample,
  output logic             full,
  output logic             empty,
  input  wire logic        pop,
  output result_t          result,
  input  wire logic        cfg_wen,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  logic      mid_push;
  logic      mid_full;
  logic      mid_empty;
  logic      mid_take;
  mid_item_t mid_in;
  mid_item_t mid_out;

  // Compute magnitudes
  fid_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .sample   (sample),
    .full     (full),
    .mid_full (mid_full),
    .mid_push (mid_push),
    .mid_item (mid_in)
  );

  // Buffer magnitudes between the two halves
  fid_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .din   (mid_in),
    .full  (mid_full),
    .pop   (mid_take),
    .dout  (mid_out),
    .empty (mid_empty)
  );

  // Decide events and hold results
  fid_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .item       (mid_out),
    .item_valid (!mid_empty),
    .item_take  (mid_take),
    .result     (result),
    .empty      (empty),
    .pop        (pop)
  );

endmodule

`default_nettype wire
